// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the cluster idle composer.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLCO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLCO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/clco_pkg.sv
// Shared types and constants of the cluster idle composer.
// Depends on nothing; imported by every module of the block.
package clco_pkg;

    localparam int NUM_CLUSTERS = 4;
    localparam int NUM_CPUS     = 8;
    localparam int CPU_SLOTS    = 8;
    localparam int CPU_W        = 3;
    localparam int CODE_W       = 3;

    localparam logic OP_ENTER = 1'b0;
    localparam logic OP_EXIT  = 1'b1;

    localparam logic [2:0] REG_BASE_STATE      = 3'd0;
    localparam logic [2:0] REG_CLUSTER_RET     = 3'd1;
    localparam logic [2:0] REG_CLUSTER_COLLAPSE = 3'd2;
    localparam logic [2:0] REG_SYSTEM_RET      = 3'd3;
    localparam logic [2:0] REG_SYSTEM_COLLAPSE = 3'd4;
    localparam logic [2:0] REG_CLUSTER_DEPTH   = 3'd5;
    localparam logic [2:0] REG_SYSTEM_DEPTH    = 3'd6;
    localparam logic [2:0] REG_CLUSTER_MAP     = 3'd7;

    localparam logic [31:0] RST_CLUSTER_RET      = 32'h0100_0034;
    localparam logic [31:0] RST_CLUSTER_COLLAPSE = 32'h0100_0044;
    localparam logic [31:0] RST_SYSTEM_RET       = 32'h0200_2344;
    localparam logic [31:0] RST_SYSTEM_COLLAPSE  = 32'h0200_3444;
    localparam logic [23:0] RST_CLUSTER_MAP      = 24'hFF_F240;

    typedef struct packed {
        logic                 op;
        logic [CPU_W-1:0]     cpu;
        logic [CPU_SLOTS-1:0] ipi_pending;
    } in_item_t;

    typedef struct packed {
        logic [31:0] suspend_state;
        logic        composed;
        logic        system_level;
        logic [31:0] cluster_entry_count;
        logic [31:0] system_entry_count;
    } out_item_t;

    typedef struct packed {
        logic [31:0] base_state;
        logic [31:0] cluster_retention_code;
        logic [31:0] cluster_collapse_code;
        logic [31:0] system_retention_code;
        logic [31:0] system_collapse_code;
        logic [1:0]  cluster_depth;
        logic [1:0]  system_depth;
        logic [23:0] cpu_cluster_map;
    } cfg_t;

    typedef struct packed {
        logic [CPU_SLOTS-1:0] idle_mask;
        logic [31:0]          cluster_count;
        logic [31:0]          system_count;
    } track_t;

endpackage

// File: rtl/core/cluster_idle_last_out_composer_top.sv
// Top level of the cluster idle composer: config registers, event pipeline, state.
// Depends on clco_pkg, clco_compose and assert_macros.svh.

// Takes one idle enter or exit event per cycle while in_stall is low and returns
// one result per event, in event order. Events pass an input register, then the
// decision logic, then a result register; the idle mask and the two entry
// counters are updated in the same cycle an event leaves the input register,
// which sets the one-event-per-cycle figure. The output register lets a new
// event be taken while a result waits to be taken. Configuration must be written
// through cfg_we, cfg_addr and cfg_wdata only while no event is in flight; the
// block itself does not enforce this.
`include "assert_macros.svh"

module cluster_idle_last_out_composer_top
    import clco_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic [2:0] cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    cfg_t      cfg_reg;
    track_t    track_reg;
    track_t    track_next;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t result;
    logic      out_free;
    logic      advance;
    logic      in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_state             <= '0;
            cfg_reg.cluster_retention_code <= RST_CLUSTER_RET;
            cfg_reg.cluster_collapse_code  <= RST_CLUSTER_COLLAPSE;
            cfg_reg.system_retention_code  <= RST_SYSTEM_RET;
            cfg_reg.system_collapse_code   <= RST_SYSTEM_COLLAPSE;
            cfg_reg.cluster_depth          <= 2'd2;
            cfg_reg.system_depth           <= 2'd2;
            cfg_reg.cpu_cluster_map        <= RST_CLUSTER_MAP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_BASE_STATE:       cfg_reg.base_state             <= cfg_wdata;
                REG_CLUSTER_RET:      cfg_reg.cluster_retention_code <= cfg_wdata;
                REG_CLUSTER_COLLAPSE: cfg_reg.cluster_collapse_code  <= cfg_wdata;
                REG_SYSTEM_RET:       cfg_reg.system_retention_code  <= cfg_wdata;
                REG_SYSTEM_COLLAPSE:  cfg_reg.system_collapse_code   <= cfg_wdata;
                REG_CLUSTER_DEPTH:    cfg_reg.cluster_depth          <= cfg_wdata[1:0];
                REG_SYSTEM_DEPTH:     cfg_reg.system_depth           <= cfg_wdata[1:0];
                REG_CLUSTER_MAP:      cfg_reg.cpu_cluster_map        <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        priority if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_comb
    begin
        priority if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    clco_compose u_compose (
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .track      (track_reg),
        .track_next (track_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            track_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                track_reg <= track_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_data;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    `CLCO_ASSERT_NXT(a_cluster_count_step, clk, rst_n,
        advance && result.composed && !result.system_level,
        track_reg.cluster_count == $past(track_reg.cluster_count) + 32'd1)
    `CLCO_ASSERT_NXT(a_exit_clears_idle, clk, rst_n,
        advance && (s1_item_reg.op == OP_EXIT),
        track_reg.idle_mask[$past(s1_item_reg.cpu)] == 1'b0)
    `CLCO_ASSERT_NXT(a_held_item_stays, clk, rst_n,
        s1_valid_reg && !advance,
        s1_valid_reg && $stable(s1_item_reg))
    `CLCO_ASSERT_IMP(a_composed_keeps_base, clk, rst_n,
        out_valid_reg && out_item_reg.composed,
        (out_item_reg.suspend_state & cfg_reg.base_state) == cfg_reg.base_state)

endmodule

// File: rtl/core/clco_compose.sv
// Decision logic for one idle event: membership, last-CPU check and code choice.
// Depends on clco_pkg.
module clco_compose
    import clco_pkg::*;
(
    input  in_item_t  item,
    input  cfg_t      cfg,
    input  track_t    track,
    output track_t    track_next,
    output out_item_t result
);

    logic [CODE_W-1:0]    codes [CPU_SLOTS];
    logic [CPU_SLOTS-1:0] has_cluster;
    logic [CPU_SLOTS-1:0] members;
    logic [CPU_SLOTS-1:0] cpu_bit;
    logic [CPU_SLOTS-1:0] mask_set;
    logic [CODE_W-1:0]    ent_code;
    logic                 ent_has;
    logic                 last_out;
    logic                 all_idle;
    logic                 do_system;
    logic                 do_cluster;
    logic [31:0]          level_code;

    always_comb
    begin
        for (int i = 0; i < CPU_SLOTS; i++)
        begin
            codes[i]       = cfg.cpu_cluster_map[CODE_W*i +: CODE_W];
            has_cluster[i] = (i < NUM_CPUS) && (codes[i] < CODE_W'(NUM_CLUSTERS));
        end
    end

    assign ent_code = codes[item.cpu];
    assign ent_has  = has_cluster[item.cpu];
    assign cpu_bit  = CPU_SLOTS'(1) << item.cpu;
    assign mask_set = track.idle_mask | cpu_bit;

    always_comb
    begin
        for (int i = 0; i < CPU_SLOTS; i++)
        begin
            members[i] = has_cluster[i] && (codes[i] == ent_code);
        end
    end

    // A fully idle system means every CPU that belongs to some cluster is idle.
    assign all_idle = (mask_set & has_cluster) == has_cluster;
    assign last_out = (item.op == OP_ENTER) && ent_has && (cfg.cluster_depth != 2'd0)
                      && ((mask_set & members) == members)
                      && ((item.ipi_pending & members) == '0);
    assign do_system  = last_out && (cfg.system_depth != 2'd0) && all_idle;
    assign do_cluster = last_out && !do_system;

    always_comb
    begin
        if (do_system)
        begin
            level_code = cfg.system_depth[1] ? cfg.system_collapse_code
                                             : cfg.system_retention_code;
        end
        else if (do_cluster)
        begin
            level_code = cfg.cluster_depth[1] ? cfg.cluster_collapse_code
                                              : cfg.cluster_retention_code;
        end
        else
        begin
            level_code = '0;
        end
    end

    always_comb
    begin
        track_next = track;
        if (item.op == OP_EXIT)
        begin
            track_next.idle_mask = track.idle_mask & ~cpu_bit;
        end
        else if (ent_has)
        begin
            track_next.idle_mask = mask_set;
        end
        if (do_system)
        begin
            track_next.system_count = track.system_count + 32'd1;
        end
        if (do_cluster)
        begin
            track_next.cluster_count = track.cluster_count + 32'd1;
        end
    end

    always_comb
    begin
        result.suspend_state       = (item.op == OP_ENTER) ? (cfg.base_state | level_code) : '0;
        result.composed            = last_out;
        result.system_level        = do_system;
        result.cluster_entry_count = track_next.cluster_count;
        result.system_entry_count  = track_next.system_count;
    end

endmodule
